### rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Clocked assertion helpers used by the checker file.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/jsv_pkg.sv
// ============================================================================
// jsv_pkg
// Types, marker codes and defaults shared by the structure validator.
// ============================================================================
package jsv_pkg;

    localparam int unsigned MAX_IMAGES_DEF = 8;
    localparam int unsigned IMG_W          = 4;

    localparam logic [7:0] MK_FILL = 8'hff;
    localparam logic [7:0] MK_SOI  = 8'hd8;
    localparam logic [7:0] MK_EOI  = 8'hd9;
    localparam logic [7:0] MK_SOS  = 8'hda;
    localparam logic [7:0] MK_DNL  = 8'hdc;
    localparam logic [7:0] MK_APP2 = 8'he2;
    localparam logic [7:0] MK_RST0 = 8'hd0;
    localparam logic [7:0] MK_RST7 = 8'hd7;
    localparam logic [7:0] MK_TEM  = 8'h01;
    localparam logic [7:0] MK_SOF7 = 8'hc7;
    localparam logic [7:0] MK_SOF9 = 8'hc9;
    localparam logic [7:0] MK_COM1 = 8'hfe;

    localparam logic [1:0] VERDICT_BUSY    = 2'd0;
    localparam logic [1:0] VERDICT_VALID   = 2'd1;
    localparam logic [1:0] VERDICT_CORRUPT = 2'd2;

    typedef logic [3:0][7:0] t_tag;
    localparam t_tag MPF_TAG = {8'h00, 8'h46, 8'h50, 8'h4d};

    typedef struct packed {
        logic [7:0] data;
        logic       eof;
        logic       is_ff;
        logic       is_00;
        logic       is_soi;
        logic       is_eoi;
        logic       is_rst;
        logic       is_tem;
        logic       has_len;
        logic       is_sos;
        logic       is_dnl;
        logic       is_app2;
        logic [3:0] tag_hit;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qout;

    typedef struct packed {
        logic  push;
        t_item item;
    } t_qin;

endpackage

### rtl/jsv_queue.sv
// ============================================================================
// jsv_queue
// Two-entry queue between the byte classifier and the parser.
// ============================================================================
module jsv_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  jsv_pkg::t_qin  i_in,
    input  logic           i_pop,
    output logic           o_full,
    output jsv_pkg::t_qout o_out
);
    import jsv_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push;
    logic       pop;

    assign o_full      = (r_cnt == 2'd2);
    assign o_out.valid = (r_cnt != 2'd0);
    assign o_out.item  = r_mem[r_rp];
    assign push        = i_in.push && !o_full;
    assign pop         = i_pop && o_out.valid;

    always_comb begin
        n_wp  = r_wp ^ push;
        n_rp  = r_rp ^ pop;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_in.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

### rtl/jsv_front.sv
// ============================================================================
// jsv_front
// Input stage: registers each byte with its marker classification.
// ============================================================================
module jsv_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_data_byte,
    input  logic          i_end_of_file,
    input  logic          i_q_full,
    output jsv_pkg::t_qin o_q
);
    import jsv_pkg::*;

    logic  r_valid, n_valid;
    t_item r_item;
    t_item cls;
    logic  accept;
    logic  push;

    always_comb begin
        cls.data    = i_data_byte;
        cls.eof     = i_end_of_file;
        cls.is_ff   = (i_data_byte == MK_FILL);
        cls.is_00   = (i_data_byte == 8'h00);
        cls.is_soi  = (i_data_byte == MK_SOI);
        cls.is_eoi  = (i_data_byte == MK_EOI);
        cls.is_rst  = (i_data_byte >= MK_RST0) && (i_data_byte <= MK_RST7);
        cls.is_tem  = (i_data_byte == MK_TEM);
        cls.has_len = ((i_data_byte >= 8'hc0) && (i_data_byte <= MK_SOF7))
                   || ((i_data_byte >= MK_SOF9) && (i_data_byte <= 8'hcf))
                   || ((i_data_byte >= MK_SOS) && (i_data_byte <= 8'hdf))
                   || ((i_data_byte >= 8'he0) && (i_data_byte <= MK_COM1));
        cls.is_sos  = (i_data_byte == MK_SOS);
        cls.is_dnl  = (i_data_byte == MK_DNL);
        cls.is_app2 = (i_data_byte == MK_APP2);
        for (int k = 0; k < 4; k++) begin
            cls.tag_hit[k] = (i_data_byte == MPF_TAG[k]);
        end
    end

    assign push    = r_valid && !i_q_full;
    assign o_stall = r_valid && i_q_full;
    assign accept  = i_valid && !o_stall;
    assign o_q.push = push;
    assign o_q.item = r_item;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

### rtl/jsv_back.sv
// ============================================================================
// jsv_back
// Marker segment parser and result register.
// ============================================================================
module jsv_back #(
    parameter int unsigned MAX_IMAGES = jsv_pkg::MAX_IMAGES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  jsv_pkg::t_qout           i_q,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [1:0]               o_verdict,
    output logic [jsv_pkg::IMG_W-1:0] o_images_done,
    output logic                     o_primary_mpf
);
    import jsv_pkg::*;

    localparam logic [3:0] PH_SOI0     = 4'd0;
    localparam logic [3:0] PH_SOI1     = 4'd1;
    localparam logic [3:0] PH_MK0      = 4'd2;
    localparam logic [3:0] PH_MK1      = 4'd3;
    localparam logic [3:0] PH_LEN_HI   = 4'd4;
    localparam logic [3:0] PH_LEN_LO   = 4'd5;
    localparam logic [3:0] PH_SOS_NC   = 4'd6;
    localparam logic [3:0] PH_DNL_HI   = 4'd7;
    localparam logic [3:0] PH_DNL_LO   = 4'd8;
    localparam logic [3:0] PH_APP2_ID  = 4'd9;
    localparam logic [3:0] PH_SKIP     = 4'd10;
    localparam logic [3:0] PH_ENT      = 4'd11;
    localparam logic [3:0] PH_ENT_FF   = 4'd12;
    localparam logic [3:0] PH_PAD      = 4'd13;
    localparam logic [3:0] PH_NEXT_SOI = 4'd14;

    localparam logic [IMG_W-1:0] IMG_LIMIT = IMG_W'(MAX_IMAGES);

    logic [3:0]       r_phase, n_phase;
    logic [15:0]      r_seg, n_seg;
    logic [15:0]      r_skip, n_skip;
    logic             r_mk_sos, n_mk_sos;
    logic             r_mk_dnl, n_mk_dnl;
    logic             r_mk_app2, n_mk_app2;
    logic [1:0]       r_idx, n_idx;
    logic             r_mis, n_mis;
    logic             r_lcn, n_lcn;
    logic             r_from_ent, n_from_ent;
    logic             r_img_mpf, n_img_mpf;
    logic             r_first_mpf, n_first_mpf;
    logic [IMG_W-1:0] r_img, n_img;
    logic             r_failed, n_failed;
    logic             r_out_valid;
    logic [1:0]       r_verdict, n_verdict;
    logic [IMG_W-1:0] r_out_img;
    logic             r_out_mpf;
    logic             take;

    assign take          = i_q.valid && (!r_out_valid || !i_stall);
    assign o_pop         = take;
    assign o_valid       = r_out_valid;
    assign o_verdict     = r_verdict;
    assign o_images_done = r_out_img;
    assign o_primary_mpf = r_out_mpf;

    always_comb begin
        t_item       it;
        logic [3:0]  pd_phase;
        logic        sk_go;
        logic [15:0] sk_len;
        logic        tm_go;
        logic [15:0] full_len;
        logic        mis_now;

        it          = i_q.item;
        n_phase     = r_phase;
        n_seg       = r_seg;
        n_skip      = r_skip;
        n_mk_sos    = r_mk_sos;
        n_mk_dnl    = r_mk_dnl;
        n_mk_app2   = r_mk_app2;
        n_idx       = r_idx;
        n_mis       = r_mis;
        n_lcn       = r_lcn;
        n_from_ent  = r_from_ent;
        n_img_mpf   = r_img_mpf;
        n_first_mpf = r_first_mpf;
        n_img       = r_img;
        n_failed    = r_failed;
        sk_go       = 1'b0;
        sk_len      = 16'd0;
        tm_go       = 1'b0;
        full_len    = {r_seg[15:8], it.data};
        mis_now     = r_mis || !it.tag_hit[r_idx];
        pd_phase    = (r_mk_sos || (r_mk_dnl && r_from_ent)) ? PH_ENT : PH_MK0;

        if (!r_failed) begin
            case (r_phase)
                PH_SOI0: begin
                    if (it.is_ff) n_phase = PH_SOI1; else n_failed = 1'b1;
                end
                PH_SOI1: begin
                    if (it.is_soi) begin
                        n_img_mpf = 1'b0;
                        n_phase   = PH_MK0;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                PH_MK0: begin
                    if (it.is_ff) n_phase = PH_MK1; else n_failed = 1'b1;
                end
                PH_MK1: begin
                    if (it.is_00) begin
                        n_failed = 1'b1;
                    end else if (!it.is_ff) begin
                        tm_go = 1'b1;
                    end
                end
                PH_LEN_HI: begin
                    n_seg   = {it.data, 8'h00};
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_seg = full_len;
                    if (r_mk_sos) begin
                        if (full_len < 16'd3) n_failed = 1'b1; else n_phase = PH_SOS_NC;
                    end else if (r_mk_dnl) begin
                        if (full_len != 16'd4) n_failed = 1'b1; else n_phase = PH_DNL_HI;
                    end else if (r_mk_app2 && full_len >= 16'd6) begin
                        n_idx   = 2'd0;
                        n_mis   = 1'b0;
                        n_phase = PH_APP2_ID;
                    end else if (full_len < 16'd2) begin
                        n_failed = 1'b1;
                    end else begin
                        sk_go  = 1'b1;
                        sk_len = full_len - 16'd2;
                    end
                end
                PH_SOS_NC: begin
                    if (it.is_00 || it.data > 8'd4
                            || r_seg != ({7'd0, it.data, 1'b0} + 16'd6)) begin
                        n_failed = 1'b1;
                    end else begin
                        sk_go  = 1'b1;
                        sk_len = r_seg - 16'd3;
                    end
                end
                PH_DNL_HI: begin
                    n_lcn   = !it.is_00;
                    n_phase = PH_DNL_LO;
                end
                PH_DNL_LO: begin
                    if (!r_lcn && it.is_00) n_failed = 1'b1; else n_phase = pd_phase;
                end
                PH_APP2_ID: begin
                    n_mis = mis_now;
                    n_idx = r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        if (!mis_now) n_img_mpf = 1'b1;
                        sk_go  = 1'b1;
                        sk_len = r_seg - 16'd6;
                    end
                end
                PH_SKIP: begin
                    n_skip = r_skip - 16'd1;
                    if (r_skip == 16'd1) n_phase = pd_phase;
                end
                PH_ENT: begin
                    if (it.is_ff) n_phase = PH_ENT_FF;
                end
                PH_ENT_FF: begin
                    if (it.is_00 || it.is_rst) begin
                        n_phase = PH_ENT;
                    end else if (!it.is_ff) begin
                        tm_go = 1'b1;
                    end
                end
                PH_PAD: begin
                    if (!it.is_00) begin
                        if (r_first_mpf && it.is_ff) n_phase = PH_NEXT_SOI;
                        else n_failed = 1'b1;
                    end
                end
                PH_NEXT_SOI: begin
                    if (it.is_soi && r_img < IMG_LIMIT) begin
                        n_img_mpf = 1'b0;
                        n_phase   = PH_MK0;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                default: begin
                    n_failed = 1'b1;
                end
            endcase
        end

        if (tm_go) begin
            if (it.is_eoi) begin
                if (r_img == '0) n_first_mpf = r_img_mpf;
                n_img   = r_img + 1'b1;
                n_phase = PH_PAD;
            end else if (it.is_soi) begin
                n_failed = 1'b1;
            end else if (it.is_tem || it.is_rst) begin
                n_phase = PH_MK0;
            end else if (!it.has_len) begin
                n_failed = 1'b1;
            end else begin
                n_mk_sos   = it.is_sos;
                n_mk_dnl   = it.is_dnl;
                n_mk_app2  = it.is_app2;
                n_from_ent = (r_phase == PH_ENT_FF);
                n_phase    = PH_LEN_HI;
            end
        end

        if (sk_go) begin
            n_skip  = sk_len;
            n_phase = (sk_len == 16'd0) ? pd_phase : PH_SKIP;
        end

        if (n_failed) begin
            n_verdict = VERDICT_CORRUPT;
        end else if (it.eof) begin
            n_verdict = (n_phase == PH_PAD) ? VERDICT_VALID : VERDICT_CORRUPT;
        end else begin
            n_verdict = VERDICT_BUSY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_verdict <= n_verdict;
            r_out_img <= n_img;
            r_out_mpf <= n_first_mpf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (take && i_q.item.eof)) begin
            r_phase     <= PH_SOI0;
            r_seg       <= 16'd0;
            r_skip      <= 16'd0;
            r_mk_sos    <= 1'b0;
            r_mk_dnl    <= 1'b0;
            r_mk_app2   <= 1'b0;
            r_idx       <= 2'd0;
            r_mis       <= 1'b0;
            r_lcn       <= 1'b0;
            r_from_ent  <= 1'b0;
            r_img_mpf   <= 1'b0;
            r_first_mpf <= 1'b0;
            r_img       <= '0;
            r_failed    <= 1'b0;
        end else if (take) begin
            r_phase     <= n_phase;
            r_seg       <= n_seg;
            r_skip      <= n_skip;
            r_mk_sos    <= n_mk_sos;
            r_mk_dnl    <= n_mk_dnl;
            r_mk_app2   <= n_mk_app2;
            r_idx       <= n_idx;
            r_mis       <= n_mis;
            r_lcn       <= n_lcn;
            r_from_ent  <= n_from_ent;
            r_img_mpf   <= n_img_mpf;
            r_first_mpf <= n_first_mpf;
            r_img       <= n_img;
            r_failed    <= n_failed;
        end
    end

endmodule

### rtl/jpeg_structure_validator.sv
// ============================================================================
// jpeg_structure_validator
// Streams a file byte by byte and reports whether its JPEG framing is sound.
// ============================================================================
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+-------------------------------
//  input   | in        | i_valid / o_stall  | data_byte, end_of_file
//  result  | out       | o_valid / i_stall  | verdict, images_done, primary_mpf
//
//  One byte per cycle sustained unless the result side stalls; a byte's
//  result passes through the classify register, queue and result register.
//  The parser state machine updates once per byte, which sets the rate.
//  Reset is synchronous and clears the parser, queue and valid flags.
//  A stall on the result side fills the two-entry queue, then the input
//  register, before o_stall rises.
module jpeg_structure_validator #(
    parameter int unsigned MAX_IMAGES = jsv_pkg::MAX_IMAGES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_end_of_file,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [1:0]                o_verdict,
    output logic [jsv_pkg::IMG_W-1:0] o_images_done,
    output logic                      o_primary_mpf
);
    import jsv_pkg::*;

    t_qin  q_in;
    t_qout q_out;
    logic  q_full;
    logic  q_pop;

    jsv_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_end_of_file (i_end_of_file),
        .i_q_full      (q_full),
        .o_q           (q_in)
    );

    jsv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_out   (q_out)
    );

    jsv_back #(
        .MAX_IMAGES (MAX_IMAGES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q           (q_out),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_verdict     (o_verdict),
        .o_images_done (o_images_done),
        .o_primary_mpf (o_primary_mpf)
    );

endmodule

### rtl/jsv_checker.sv
// ============================================================================
// jsv_checker
// Port-level checks on the structure validator's result channel.
// ============================================================================
`include "assert_macros.svh"

module jsv_checker #(
    parameter int unsigned MAX_IMAGES = jsv_pkg::MAX_IMAGES_DEF
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [1:0]                o_verdict,
    input logic [jsv_pkg::IMG_W-1:0] o_images_done,
    input logic                      o_primary_mpf
);
    import jsv_pkg::*;

    `ASSERT_CLK(a_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_verdict) && $stable(o_images_done) && $stable(o_primary_mpf), "stalled result changed")
    `ASSERT_CLK(a_code, i_clk, i_rst_n, o_valid |-> o_verdict == VERDICT_BUSY || o_verdict == VERDICT_VALID || o_verdict == VERDICT_CORRUPT, "bad verdict code")
    `ASSERT_CLK(a_imgs, i_clk, i_rst_n, o_valid |-> o_images_done <= IMG_W'(MAX_IMAGES), "image count above limit")
    `ASSERT_CLK(a_mpf, i_clk, i_rst_n, o_valid && o_images_done > 1 |-> o_primary_mpf, "second image without MPF primary")
    `ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind jpeg_structure_validator jsv_checker #(
    .MAX_IMAGES (MAX_IMAGES)
) u_jsv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_verdict     (o_verdict),
    .o_images_done (o_images_done),
    .o_primary_mpf (o_primary_mpf)
);
